@@ hw/rtl/sorted_table_interpolation_defines.svh @@
// Assertion macros used by the checker.
`ifndef SORTED_TABLE_INTERPOLATION_DEFINES_SVH
`define SORTED_TABLE_INTERPOLATION_DEFINES_SVH

// Implication checked every clock, quiet during reset.
`define STI_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: lbl failed");

// Non-overlapping implication: the consequent is checked after the antecedent's clock.
`define STI_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: lbl failed");

`endif

@@ hw/rtl/sti_pkg.sv @@
package sti_pkg;

  localparam int DEFAULT_DEPTH = 4096;
  localparam int CountW = 13;

  typedef struct packed {
    logic        opcode;
    logic        load_channel;
    logic [11:0] load_index;
    logic [15:0] load_sample;
    logic signed [15:0] load_gauss;
    logic [15:0] query_value_0;
    logic [15:0] query_value_1;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] gauss_out_0;
    logic signed [15:0] gauss_out_1;
    logic               in_range;
  } out_item_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,     // set up search for current channel
    ST_SREQ,     // issue memory read at first+step, or read found entry when count is zero
    ST_SCMP,     // compare returned sample
    ST_FREQ,     // unused; the found entry is read from ST_SREQ
    ST_FWAIT,
    ST_PREQ,     // unused; the entry below is read from ST_FWAIT
    ST_PWAIT,
    ST_MUL,
    ST_DIV,
    ST_FIN,      // add and saturate
    ST_LREQ,     // read first, then last entry for range check
    ST_LWAIT,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic init;
    logic rd_probe;
    logic cmp;
    logic rd_found;
    logic cap_found;
    logic rd_prev;
    logic cap_prev;
    logic mul;
    logic div_step;
    logic fin_direct;
    logic fin_interp;
    logic rd_last;
    logic cap_last;
    logic rd_first;
    logic cap_first;
    logic next_ch;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic direct;   // exact hit / end entry
    logic equal;    // neighbours equal
    logic div_done;
    logic ch;
  } stat_t;

endpackage

@@ hw/rtl/sorted_table_interpolation.sv @@
// channel | signals                               | timing
// command | start, busy, item                     | taken when start && !busy
// result  | done, result                          | one-cycle strobe
// config  | entry_count_we, entry_count           | written when entry_count_we
// An in-range load is written when taken and does not raise busy. A query
// keeps busy high for a binary search on the single table read port,
// neighbour and range reads per channel, and a serial divide and final add
// per channel that interpolates; done rises as busy falls. A search makes
// at most floor(log2(n))+1 probes for n entries. Tables have no reset; the
// count register resets to 4096. Results cannot be held off.
module sorted_table_interpolation #(
  parameter int TableDepth = sti_pkg::DEFAULT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  sti_pkg::in_item_t          item,
  output logic                       done,
  output sti_pkg::out_item_t         result,
  input  logic                       entry_count_we,
  input  logic [sti_pkg::CountW-1:0] entry_count
);

  sti_pkg::cmd_t  cmd;
  sti_pkg::stat_t stat;

  sti_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start),
    .is_query(item.opcode == sti_pkg::OP_QUERY),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  sti_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk(clk), .rst(rst), .entry_count_we(entry_count_we),
    .entry_count(entry_count), .item(item), .cmd(cmd), .stat(stat),
    .done(done), .result(result)
  );

endmodule

@@ hw/rtl/sti_ctrl.sv @@
module sti_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           is_query,
  input  sti_pkg::stat_t stat,
  output sti_pkg::cmd_t  cmd,
  output logic           busy
);

  sti_pkg::state_t state, state_next;
  logic            lastph, lastph_next; // 0: range low read, 1: range high read

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sti_pkg::ST_IDLE;
      lastph <= 1'b0;
    end else begin
      state  <= state_next;
      lastph <= lastph_next;
    end
  end

  always_comb begin
    cmd         = '0;
    state_next  = state;
    lastph_next = lastph;
    busy        = (state != sti_pkg::ST_IDLE);
    case (state)
      sti_pkg::ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (is_query) state_next = sti_pkg::ST_INIT;
        end
      end
      sti_pkg::ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = sti_pkg::ST_SREQ;
      end
      sti_pkg::ST_SREQ: begin
        if (stat.count_zero) begin
          cmd.rd_found = 1'b1;
          state_next   = sti_pkg::ST_FWAIT;
        end else begin
          cmd.rd_probe = 1'b1;
          state_next   = sti_pkg::ST_SCMP;
        end
      end
      sti_pkg::ST_SCMP: begin
        cmd.cmp    = 1'b1;
        state_next = sti_pkg::ST_SREQ;
      end
      sti_pkg::ST_FWAIT: begin
        cmd.cap_found = 1'b1;
        cmd.rd_prev   = 1'b1;
        state_next    = sti_pkg::ST_PWAIT;
      end
      sti_pkg::ST_PWAIT: begin
        cmd.cap_prev = 1'b1;
        state_next   = sti_pkg::ST_MUL;
      end
      sti_pkg::ST_MUL: begin
        if (stat.direct || stat.equal) begin
          cmd.fin_direct = 1'b1;
          state_next     = sti_pkg::ST_LREQ;
        end else begin
          cmd.mul    = 1'b1;
          state_next = sti_pkg::ST_DIV;
        end
      end
      sti_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = sti_pkg::ST_FIN;
      end
      sti_pkg::ST_FIN: begin
        cmd.fin_interp = 1'b1;
        state_next     = sti_pkg::ST_LREQ;
      end
      sti_pkg::ST_LREQ: begin
        if (lastph) cmd.rd_last = 1'b1;
        else        cmd.rd_first = 1'b1;
        state_next = sti_pkg::ST_LWAIT;
      end
      sti_pkg::ST_LWAIT: begin
        if (lastph) begin
          cmd.cap_last = 1'b1;
          lastph_next  = 1'b0;
          if (stat.ch) state_next = sti_pkg::ST_DONE;
          else begin
            cmd.next_ch = 1'b1;
            state_next  = sti_pkg::ST_INIT;
          end
        end else begin
          cmd.cap_first = 1'b1;
          lastph_next   = 1'b1;
          state_next    = sti_pkg::ST_LREQ;
        end
      end
      sti_pkg::ST_DONE: begin
        cmd.emit   = 1'b1;
        state_next = sti_pkg::ST_IDLE;
      end
      default: state_next = sti_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/sti_datapath.sv @@
module sti_datapath #(
  parameter int TableDepth = sti_pkg::DEFAULT_DEPTH,
  localparam int IdxW = $clog2(TableDepth),
  localparam int CntW = $clog2(TableDepth + 1),
  localparam int AddrW = IdxW + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         entry_count_we,
  input  logic [sti_pkg::CountW-1:0]   entry_count,
  input  sti_pkg::in_item_t            item,
  input  sti_pkg::cmd_t                cmd,
  output sti_pkg::stat_t               stat,
  output logic                         done,
  output sti_pkg::out_item_t           result
);

  logic [sti_pkg::CountW-1:0] cnt_reg;
  logic [CntW-1:0]            n_used;
  sti_pkg::in_item_t          cur;

  logic [15:0] smem [2*TableDepth];
  logic [15:0] gmem [2*TableDepth];
  logic [AddrW-1:0] raddr;
  logic             ren;
  logic [15:0]      rs, rg;

  logic            ch;
  logic [CntW-1:0] first, count;
  logic [CntW-1:0] step;
  logic [IdxW-1:0] idx;
  logic [15:0]     q;
  logic [15:0]     s1, s0;
  logic signed [15:0] g1, g0;
  logic            direct;
  logic [33:0]     prod;      // |g0-g1| * (next-q)
  logic            neg;
  logic [16:0]     den;
  logic [35:0]     rem;
  logic [17:0]     quo;
  logic            ovf;       // quotient needs more than 18 bits
  logic [5:0]      dcnt;
  logic signed [15:0] out0, out1;
  logic            inr;

  always_ff @(posedge clk) begin
    if (rst) cnt_reg <= sti_pkg::CountW'(4096);
    else if (entry_count_we) cnt_reg <= entry_count;
  end

  always_comb begin
    if (cnt_reg == '0) n_used = CntW'(1);
    else if ({19'd0, cnt_reg} > 32'(TableDepth)) n_used = CntW'(TableDepth);
    else n_used = CntW'(cnt_reg);
  end

  assign q    = ch ? cur.query_value_1 : cur.query_value_0;
  assign step = count >> 1;

  logic [CntW-1:0] found_c;
  assign found_c = (first > n_used - CntW'(1)) ? n_used - CntW'(1) : first;

  always_comb begin
    ren   = 1'b1;
    raddr = {ch, idx};
    if (cmd.rd_probe)      raddr = {ch, IdxW'(first + step)};
    else if (cmd.rd_found) raddr = {ch, found_c[IdxW-1:0]};
    else if (cmd.rd_prev)  raddr = {ch, idx - IdxW'(1)};
    else if (cmd.rd_first) raddr = {ch, IdxW'(0)};
    else if (cmd.rd_last)  raddr = {ch, IdxW'(n_used - CntW'(1))};
    else ren = 1'b0;
  end

  // table memory, one write and one read port
  always_ff @(posedge clk) begin
    if (cmd.latch && item.opcode == sti_pkg::OP_LOAD
        && 32'(item.load_index) < 32'(TableDepth)) begin
      smem[{item.load_channel, IdxW'(item.load_index)}] <= item.load_sample;
      gmem[{item.load_channel, IdxW'(item.load_index)}] <= item.load_gauss;
    end
    if (ren) begin
      rs <= smem[raddr];
      rg <= gmem[raddr];
    end
  end

  logic signed [16:0] gdiff;
  logic [16:0]        gabs;
  assign gdiff = 17'(g0) - 17'(g1);
  assign gabs  = gdiff[16] ? 17'(-gdiff) : gdiff;

  logic [35:0] rem_sh;
  logic [35:0] dsh;
  logic [35:0] rem_init;
  assign rem_sh   = {rem[34:0], 1'b0};
  assign dsh      = {19'd0, den};
  assign rem_init = {1'b0, prod, 1'b0} + 36'(den);

  logic signed [19:0] sum;
  assign sum = 20'(g1) + (neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo}));

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.latch) ch <= 1'b0;
      else if (cmd.next_ch) ch <= 1'b1;
    end
    if (cmd.latch) cur <= item;
    if (cmd.latch) inr <= 1'b1;
    if (cmd.init) begin
      first <= '0;
      count <= n_used;
    end
    if (cmd.cmp) begin
      if (rs < q) begin
        first <= first + step + CntW'(1);
        count <= count - step - CntW'(1);
      end else count <= step;
    end
    if (cmd.rd_found) idx <= found_c[IdxW-1:0];
    if (cmd.cap_found) begin
      s1 <= rs;
      g1 <= rg;
      direct <= (rs == q) || (idx == '0) || (32'(idx) == 32'(n_used) - 1);
    end
    if (cmd.cap_prev) begin
      s0 <= rs;
      g0 <= rg;
    end
    if (cmd.fin_direct) begin
      if (ch) out1 <= direct ? g1 : g0;
      else    out0 <= direct ? g1 : g0;
    end
    if (cmd.mul) begin
      prod <= 34'(gabs) * 34'(17'(s1) - 17'(q));
      neg  <= gdiff[16] ^ (s1 < s0);
      den  <= (s1 < s0) ? 17'(s0) - 17'(s1) : 17'(s1) - 17'(s0);
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      // quotient p/d rounded, as floor((2p+d)/(2d)), restoring, one bit per cycle
      if (dcnt == '0) begin
        rem  <= rem_init;
        ovf  <= (rem_init[35:18] >= {den, 1'b0});
        quo  <= '0;
        den  <= {den[15:0], 1'b0};
        dcnt <= dcnt + 6'd1;
      end else begin
        if (rem_sh[35:18] >= 18'(dsh)) begin
          rem <= {rem_sh[35:18] - 18'(dsh), rem_sh[17:0]};
          quo <= {quo[16:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[16:0], 1'b0};
        end
        dcnt <= dcnt + 6'd1;
      end
    end
    if (cmd.fin_interp) begin
      if (ovf) begin
        if (ch) out1 <= neg ? 16'sh8000 : 16'sh7fff;
        else    out0 <= neg ? 16'sh8000 : 16'sh7fff;
      end else if (sum > 20'sd32767) begin
        if (ch) out1 <= 16'sh7fff; else out0 <= 16'sh7fff;
      end else if (sum < -20'sd32768) begin
        if (ch) out1 <= -16'sh8000; else out0 <= -16'sh8000;
      end else begin
        if (ch) out1 <= sum[15:0]; else out0 <= sum[15:0];
      end
    end
    if (cmd.cap_first && q < rs) inr <= 1'b0;
    if (cmd.cap_last && q > rs) inr <= 1'b0;
  end

  assign stat.count_zero = (count == '0);
  assign stat.direct     = direct;
  assign stat.equal      = (s0 == s1);
  assign stat.div_done   = (dcnt == 6'd18);
  assign stat.ch         = ch;

  assign result.gauss_out_0 = out0;
  assign result.gauss_out_1 = out1;
  assign result.in_range    = inr;

endmodule

@@ hw/rtl/sti_checker.sv @@
`include "sorted_table_interpolation_defines.svh"

module sti_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `STI_ASSERT_IMP(a_done_busy, clk, rst, done, !busy)
  `STI_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `STI_ASSERT_NEXT(a_idle_stays, clk, rst, !busy && !start, !busy && !done)

endmodule

bind sorted_table_interpolation sti_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
